FILE: rtl/core/eabv_pkg.sv
package eabv_pkg;

    localparam int WORK_FRAC = 30;
    localparam int LANES     = 3;

    typedef logic signed [15:0] t_ang;
    typedef logic signed [32:0] t_work;
    typedef logic signed [31:0] t_q30;
    typedef logic        [15:0] t_out;

    typedef struct packed {
        t_work      x;
        t_work      y;
        t_work      r;
        logic [1:0] q;
    } t_lane;

    typedef t_lane [LANES-1:0] t_lanes;

    localparam t_work GAIN_Q30 = 33'sh026DD3B6A;

    localparam logic [31:0] ATAN [32] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
    };

    // q30 product, rounded half up with floor shift
    function automatic t_q30 mulq(input t_q30 a, input t_q30 b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd536870912;
        return p[61:30];
    endfunction

endpackage

FILE: rtl/core/eabv_angle.sv
module eabv_angle (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  eabv_pkg::t_ang    i_ang [eabv_pkg::LANES],
    output logic              o_valid,
    output eabv_pkg::t_lanes  o_lanes
);

    logic [4:0]  r_valid;
    logic [14:0] r_a   [eabv_pkg::LANES];
    logic [14:0] r_a2  [eabv_pkg::LANES];
    logic [8:0]  r_qa  [eabv_pkg::LANES];
    logic [8:0]  r_qa2 [eabv_pkg::LANES];
    logic [8:0]  r_qa3 [eabv_pkg::LANES];
    logic [5:0]  r_ra  [eabv_pkg::LANES];
    logic [22:0] r_base[eabv_pkg::LANES];
    logic [4:0]  r_sml [eabv_pkg::LANES];
    eabv_pkg::t_lanes r_lanes;

    logic signed [16:0] n_red  [eabv_pkg::LANES];
    logic [35:0]        n_qp   [eabv_pkg::LANES];
    logic [14:0]        n_rdf  [eabv_pkg::LANES];
    logic [11:0]        n_t    [eabv_pkg::LANES];
    logic [29:0]        n_sp   [eabv_pkg::LANES];
    logic [31:0]        n_z    [eabv_pkg::LANES];

    always_comb begin
        for (int k = 0; k < eabv_pkg::LANES; k++) begin
            n_red[k] = 17'(i_ang[k]);
            if (n_red[k] < -17'sd23040) begin
                n_red[k] = n_red[k] + 17'sd46080;
            end else if (n_red[k] < 17'sd0) begin
                n_red[k] = n_red[k] + 17'sd23040;
            end else if (n_red[k] >= 17'sd23040) begin
                n_red[k] = n_red[k] - 17'sd23040;
            end
            // divide by 45 through reciprocal
            n_qp[k]  = 36'(r_a[k]) * 36'd1491309;
            n_rdf[k] = r_a2[k] - 15'(r_qa[k] * 15'd45);
            n_t[k]   = 12'(r_ra[k]) * 12'd46 + 12'd45;
            n_sp[k]  = 30'(n_t[k]) * 30'd186414;
            n_z[k]   = {r_qa3[k], 23'd0} + 32'(r_base[k]) + 32'(r_sml[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < eabv_pkg::LANES; k++) begin
                r_a[k]    <= n_red[k][14:0];
                r_qa[k]   <= n_qp[k][34:26];
                r_a2[k]   <= r_a[k];
                r_ra[k]   <= n_rdf[k][5:0];
                r_qa2[k]  <= r_qa[k];
                r_base[k] <= 23'(r_ra[k] * 23'd186413);
                r_sml[k]  <= n_sp[k][28:24];
                r_qa3[k]  <= r_qa2[k];
                r_lanes[k].x <= eabv_pkg::GAIN_Q30;
                r_lanes[k].y <= '0;
                r_lanes[k].r <= {3'd0, n_z[k][29:0]};
                r_lanes[k].q <= n_z[k][31:30];
            end
        end
    end

    assign o_valid = r_valid[4];
    assign o_lanes = r_lanes;

endmodule

FILE: rtl/core/eabv_cell.sv
module eabv_cell #(
    parameter int I = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  eabv_pkg::t_lanes  i_lanes,
    output logic              o_valid,
    output eabv_pkg::t_lanes  o_lanes
);

    localparam eabv_pkg::t_work AT = {1'b0, eabv_pkg::ATAN[I]};

    logic             r_valid;
    eabv_pkg::t_lanes r_lanes;
    eabv_pkg::t_lanes n_lanes;

    always_comb begin
        for (int k = 0; k < eabv_pkg::LANES; k++) begin
            n_lanes[k].q = i_lanes[k].q;
            if (!i_lanes[k].r[32]) begin
                n_lanes[k].x = i_lanes[k].x - (i_lanes[k].y >>> I);
                n_lanes[k].y = i_lanes[k].y + (i_lanes[k].x >>> I);
                n_lanes[k].r = i_lanes[k].r - AT;
            end else begin
                n_lanes[k].x = i_lanes[k].x + (i_lanes[k].y >>> I);
                n_lanes[k].y = i_lanes[k].y - (i_lanes[k].x >>> I);
                n_lanes[k].r = i_lanes[k].r + AT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lanes <= n_lanes;
        end
    end

    assign o_valid = r_valid;
    assign o_lanes = r_lanes;

endmodule

FILE: rtl/core/eabv_combine.sv
module eabv_combine #(
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  eabv_pkg::t_lanes  i_lanes,
    output logic              o_valid,
    output eabv_pkg::t_out    o_out [9]
);

    localparam int SH = eabv_pkg::WORK_FRAC - OUT_FRAC_BITS;
    localparam logic signed [33:0] RND = (34'sd1 <<< SH) >>> 1;
    localparam logic signed [33:0] LIM = 34'sd1 <<< OUT_FRAC_BITS;
    localparam eabv_pkg::t_work ONE = 33'sd1 <<< eabv_pkg::WORK_FRAC;

    function automatic eabv_pkg::t_out to_out(input eabv_pkg::t_work v);
        logic signed [33:0] w;
        w = (34'(v) + RND) >>> SH;
        if (w > LIM) begin
            w = LIM;
        end else if (w < -LIM) begin
            w = -LIM;
        end
        return w[15:0];
    endfunction

    function automatic eabv_pkg::t_q30 sat1(input eabv_pkg::t_work v);
        eabv_pkg::t_work w;
        w = v;
        if (w > ONE) begin
            w = ONE;
        end else if (w < -ONE) begin
            w = -ONE;
        end
        return w[31:0];
    endfunction

    logic [3:0] r_valid;

    eabv_pkg::t_q30 r_s [eabv_pkg::LANES];
    eabv_pkg::t_q30 r_c [eabv_pkg::LANES];
    eabv_pkg::t_q30 n_s [eabv_pkg::LANES];
    eabv_pkg::t_q30 n_c [eabv_pkg::LANES];
    eabv_pkg::t_q30 n_sv, n_cv;

    // stage two products
    eabv_pkg::t_q30 r_srsp, r_crsp, r_cpcy, r_cpsy, r_sp, r_crsy, r_crcy;
    eabv_pkg::t_q30 r_srsy, r_srcy, r_srcp, r_crcp, r_cy, r_sy;
    // stage three
    eabv_pkg::t_q30 r_pa, r_pb, r_pc, r_pd, r3_cpcy, r3_cpsy, r3_sp, r3_crsy;
    eabv_pkg::t_q30 r3_crcy, r3_srsy, r3_srcy, r3_srcp, r3_crcp;

    eabv_pkg::t_out r_out [9];
    eabv_pkg::t_work n_v  [9];

    always_comb begin
        n_sv = '0;
        n_cv = '0;
        for (int k = 0; k < eabv_pkg::LANES; k++) begin
            n_cv = sat1(i_lanes[k].x);
            n_sv = sat1(i_lanes[k].y);
            case (i_lanes[k].q)
                2'd0: begin
                    n_s[k] = n_sv;
                    n_c[k] = n_cv;
                end
                2'd1: begin
                    n_s[k] = n_cv;
                    n_c[k] = -n_sv;
                end
                2'd2: begin
                    n_s[k] = -n_sv;
                    n_c[k] = -n_cv;
                end
                default: begin
                    n_s[k] = -n_cv;
                    n_c[k] = n_sv;
                end
            endcase
        end
    end

    always_comb begin
        n_v[0] = 33'(r3_cpcy);
        n_v[1] = 33'(r3_cpsy);
        n_v[2] = -33'(r3_sp);
        n_v[3] = 33'(r3_crsy) - 33'(r_pa);
        n_v[4] = -33'(r_pb) - 33'(r3_crcy);
        n_v[5] = -33'(r3_srcp);
        n_v[6] = 33'(r_pc) + 33'(r3_srsy);
        n_v[7] = 33'(r_pd) - 33'(r3_srcy);
        n_v[8] = 33'(r3_crcp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    // lane order: pitch, yaw, roll
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < eabv_pkg::LANES; k++) begin
                r_s[k] <= n_s[k];
                r_c[k] <= n_c[k];
            end
            r_srsp <= eabv_pkg::mulq(r_s[2], r_s[0]);
            r_crsp <= eabv_pkg::mulq(r_c[2], r_s[0]);
            r_cpcy <= eabv_pkg::mulq(r_c[0], r_c[1]);
            r_cpsy <= eabv_pkg::mulq(r_c[0], r_s[1]);
            r_crsy <= eabv_pkg::mulq(r_c[2], r_s[1]);
            r_crcy <= eabv_pkg::mulq(r_c[2], r_c[1]);
            r_srsy <= eabv_pkg::mulq(r_s[2], r_s[1]);
            r_srcy <= eabv_pkg::mulq(r_s[2], r_c[1]);
            r_srcp <= eabv_pkg::mulq(r_s[2], r_c[0]);
            r_crcp <= eabv_pkg::mulq(r_c[2], r_c[0]);
            r_sp   <= r_s[0];
            r_cy   <= r_c[1];
            r_sy   <= r_s[1];
            r_pa    <= eabv_pkg::mulq(r_srsp, r_cy);
            r_pb    <= eabv_pkg::mulq(r_srsp, r_sy);
            r_pc    <= eabv_pkg::mulq(r_crsp, r_cy);
            r_pd    <= eabv_pkg::mulq(r_crsp, r_sy);
            r3_cpcy <= r_cpcy;
            r3_cpsy <= r_cpsy;
            r3_sp   <= r_sp;
            r3_crsy <= r_crsy;
            r3_crcy <= r_crcy;
            r3_srsy <= r_srsy;
            r3_srcy <= r_srcy;
            r3_srcp <= r_srcp;
            r3_crcp <= r_crcp;
            for (int j = 0; j < 9; j++) begin
                r_out[j] <= to_out(n_v[j]);
            end
        end
    end

    assign o_valid = r_valid[3];
    assign o_out   = r_out;

endmodule

FILE: rtl/core/euler_angles_to_basis_vectors_top.sv
// Euler angles (degrees, 6 fraction bits) in, forward/right/up unit vectors out.
// Fully pipelined: one request is taken every cycle while the output is not
// stalled. Its result passes through a five-stage angle reduction, then a chain of
// CORDIC cells, one per stage, then a four-stage product and rounding tail. A
// stall on the output freezes the whole pipeline; the output register holds its
// result until taken.
module euler_angles_to_basis_vectors_top #(
    parameter int OUT_FRAC_BITS = 14,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [15:0]   i_pitch_deg,
    input  logic signed [15:0]   i_yaw_deg,
    input  logic signed [15:0]   i_roll_deg,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [15:0]   o_forward_x,
    output logic signed [15:0]   o_forward_y,
    output logic signed [15:0]   o_forward_z,
    output logic signed [15:0]   o_right_x,
    output logic signed [15:0]   o_right_y,
    output logic signed [15:0]   o_right_z,
    output logic signed [15:0]   o_up_x,
    output logic signed [15:0]   o_up_y,
    output logic signed [15:0]   o_up_z
);

    logic             w_en;
    eabv_pkg::t_ang   w_ang   [eabv_pkg::LANES];
    eabv_pkg::t_lanes w_lanes [CORDIC_STAGES+1];
    logic             w_valid [CORDIC_STAGES+1];
    eabv_pkg::t_out   w_out   [9];

    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    assign w_ang[0] = i_pitch_deg;
    assign w_ang[1] = i_yaw_deg;
    assign w_ang[2] = i_roll_deg;

    eabv_angle u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_ang   (w_ang),
        .o_valid (w_valid[0]),
        .o_lanes (w_lanes[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        eabv_cell #(
            .I (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_lanes (w_lanes[g]),
            .o_valid (w_valid[g+1]),
            .o_lanes (w_lanes[g+1])
        );
    end

    eabv_combine #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_valid[CORDIC_STAGES]),
        .i_lanes (w_lanes[CORDIC_STAGES]),
        .o_valid (o_valid),
        .o_out   (w_out)
    );

    assign o_forward_x = w_out[0];
    assign o_forward_y = w_out[1];
    assign o_forward_z = w_out[2];
    assign o_right_x   = w_out[3];
    assign o_right_y   = w_out[4];
    assign o_right_z   = w_out[5];
    assign o_up_x      = w_out[6];
    assign o_up_y      = w_out[7];
    assign o_up_z      = w_out[8];

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int OFB    = 14;
    localparam int STAGES = 16;
    localparam int LAT    = 9 + STAGES;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [15:0] fx, fy, fz, rx, ry, rz, ux, uy, uz;
    } t_basis;

    class basis_scoreboard;
        t_basis pending[$];
        int     errors;

        function longint asr(longint v, int s);
            return v >>> s;
        endfunction

        function void sin_cos(logic [15:0] raw, output longint s, output longint c);
            longint a, r, x, y, nx, sv, cv, one;
            logic [31:0] z;
            logic [1:0] q;
            one = 64'sd1 <<< 30;
            a = longint'($signed(raw));
            a = a % 23040;
            if (a < 0) a += 23040;
            z = 32'(((a <<< 32) + 11520) / 23040);
            q = z[31:30];
            r = longint'(z[29:0]);
            x = longint'(eabv_pkg::GAIN_Q30);
            y = 0;
            for (int i = 0; i < STAGES && i < 32; i++) begin
                if (r >= 0) begin
                    nx = x - asr(y, i);
                    y = y + asr(x, i);
                    r -= longint'(eabv_pkg::ATAN[i]);
                end else begin
                    nx = x + asr(y, i);
                    y = y - asr(x, i);
                    r += longint'(eabv_pkg::ATAN[i]);
                end
                x = nx;
            end
            cv = x > one ? one : (x < -one ? -one : x);
            sv = y > one ? one : (y < -one ? -one : y);
            case (q)
                2'd0: begin s = sv; c = cv; end
                2'd1: begin s = cv; c = -sv; end
                2'd2: begin s = -sv; c = -cv; end
                default: begin s = -cv; c = sv; end
            endcase
        endfunction

        function longint prod(longint a, longint b);
            return (a * b + (64'sd1 <<< 29)) >>> 30;
        endfunction

        function logic [15:0] narrow(longint v);
            longint lim;
            lim = 64'sd1 <<< OFB;
            if (OFB < 30) v = (v + (64'sd1 <<< (29 - OFB))) >>> (30 - OFB);
            if (v > lim) v = lim;
            if (v < -lim) v = -lim;
            return v[15:0];
        endfunction

        function void note_request(logic [15:0] p, logic [15:0] yw, logic [15:0] rl);
            longint sp, cp, sy, cy, sr, cr, srsp, crsp;
            t_basis e;
            sin_cos(p, sp, cp);
            sin_cos(yw, sy, cy);
            sin_cos(rl, sr, cr);
            srsp = prod(sr, sp);
            crsp = prod(cr, sp);
            e.fx = narrow(prod(cp, cy));
            e.fy = narrow(prod(cp, sy));
            e.fz = narrow(-sp);
            e.rx = narrow(-prod(srsp, cy) + prod(cr, sy));
            e.ry = narrow(-prod(srsp, sy) - prod(cr, cy));
            e.rz = narrow(-prod(sr, cp));
            e.ux = narrow(prod(crsp, cy) + prod(sr, sy));
            e.uy = narrow(prod(crsp, sy) - prod(sr, cy));
            e.uz = narrow(prod(cr, cp));
            pending.push_back(e);
        endfunction

        function void cmp(string n, logic [15:0] e, logic [15:0] a);
            if (e !== a) begin
                $error("%s expected %h actual %h", n, e, a);
                errors++;
            end
        endfunction

        function void check_result(t_basis a);
            t_basis e;
            if (pending.size() == 0) begin
                $error("unexpected result");
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("forward_x", e.fx, a.fx);
            cmp("forward_y", e.fy, a.fy);
            cmp("forward_z", e.fz, a.fz);
            cmp("right_x", e.rx, a.rx);
            cmp("right_y", e.ry, a.ry);
            cmp("right_z", e.rz, a.rz);
            cmp("up_x", e.ux, a.ux);
            cmp("up_y", e.uy, a.uy);
            cmp("up_z", e.uz, a.uz);
        endfunction
    endclass

    logic i_clk, i_rst_n, i_valid, i_stall, o_valid, o_stall;
    logic signed [15:0] i_pitch_deg, i_yaw_deg, i_roll_deg;
    logic signed [15:0] o_forward_x, o_forward_y, o_forward_z;
    logic signed [15:0] o_right_x, o_right_y, o_right_z, o_up_x, o_up_y, o_up_z;

    basis_scoreboard sb;
    int  send_idle, recv_stall;
    bit  hold_off;
    longint cycles;

    euler_angles_to_basis_vectors_top #(.OUT_FRAC_BITS(OFB), .CORDIC_STAGES(STAGES)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_pitch_deg(i_pitch_deg), .i_yaw_deg(i_yaw_deg), .i_roll_deg(i_roll_deg),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_forward_x(o_forward_x), .o_forward_y(o_forward_y), .o_forward_z(o_forward_z),
        .o_right_x(o_right_x), .o_right_y(o_right_y), .o_right_z(o_right_z),
        .o_up_x(o_up_x), .o_up_y(o_up_y), .o_up_z(o_up_z)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // result side
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result({o_forward_x, o_forward_y, o_forward_z, o_right_x, o_right_y,
                             o_right_z, o_up_x, o_up_y, o_up_z});
        if (hold_off) i_stall <= 1'b1;
        else i_stall <= ($urandom_range(99) < recv_stall);
    end

    task automatic send_request(logic [15:0] p, logic [15:0] yw, logic [15:0] rl);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pitch_deg <= p;
        i_yaw_deg <= yw;
        i_roll_deg <= rl;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(p, yw, rl);
    endtask

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(3))
            0: return 16'($urandom_range(90 * 64 * 4) - 11520);
            1: return 16'($urandom_range(8) * 1440 + $urandom_range(2) - 1);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LAT + 5) @(posedge i_clk);
    endtask

    initial begin
        logic [15:0] corner[$];
        sb = new();
        cycles = 0;
        hold_off = 0;
        send_idle = 0;
        recv_stall = 0;
        i_rst_n = 0; i_valid = 0; i_stall = 0;
        i_pitch_deg = 0; i_yaw_deg = 0; i_roll_deg = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        corner = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sd5760, 16'sd11520, 16'sd17280,
                   16'sd23040, -16'sd23040, 16'sd23039, -16'sd1, 16'sd1, 16'sd2880,
                   -16'sd5760, -16'sd19456};
        foreach (corner[k])
            send_request(corner[k], corner[(k + 3) % corner.size()],
                         corner[(k + 7) % corner.size()]);
        send_request(16'sd5760, 16'sd0, 16'sd0);
        send_request(-16'sd5760, 16'sd2880, 16'sd11520);
        send_request(16'sd2880, 16'sd2880, 16'sd2880);
        send_request(16'hAAAA, 16'h5555, 16'hFFFF);
        send_request(16'h5555, 16'hAAAA, 16'h0001);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle  = (ph == 1 || ph == 3) ? (ph == 1 ? 52 : 14) : 0;
            recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 52 : 14) : 0;
            if (ph == 0) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (100) @(posedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int n = 0; n < 200; n++)
                send_request(rand_angle(), rand_angle(), rand_angle());
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) $display("tb: PASS");
        else $display("tb: FAIL");
        $finish;
    end
endmodule
